// ===== rtl/dtmps_pkg.sv =====
// shared types and character codes for the decimal tape min prefix sum block
package dtmps_pkg;

   localparam int unsigned WORD_W = 64;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // fourth code unused, behaves as skipping
   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   // token closed in this step, handed from the parser to the tally
   typedef struct packed {
      logic              close;
      logic [WORD_W-1:0] value;
      logic              neg_ovf;
      logic              digit_ovf;
   } token_type;

   // result produced by the tally in this step
   typedef struct packed {
      logic              emit;
      logic [WORD_W-1:0] final_balance;
      logic [WORD_W-1:0] lowest_balance;
      logic              overflow;
   } tally_type;

endpackage

// ===== rtl/decimal_tape_min_prefix_sum.sv =====
// top level: byte stream in, tape balances out, input and result registers
//
// reads an ascii tape one byte per transfer. bytes other than '-' and digits
// are skipped; a token is an optional '-' and digits, a lone '-' is zero, and
// the byte ending a token is consumed with it. the first token of a tape is
// the entry count, each later token adds to a 64-bit balance, and the lowest
// prefix balance (empty prefix = 0) is tracked. after the last entry, or at
// once for a count of zero or less, one result transfer carries the final
// balance, the lowest balance and a sticky overflow flag (digit, negation or
// sum overflow, values wrap). req_stream_end closes a pending token and, if
// a header was seen, reports the balances so far; all state is then cleared.
// timing: a byte is taken into the input register at its transfer edge and
// processed from there by the parser and tally into the result register,
// which raises rsp_valid for the byte that completes a tape; one byte is
// taken per cycle while the result side keeps up, and a result waiting for
// rsp_ready holds the input register, the only loop being the per-byte
// state update (times-ten shift-add, 64-bit add and signed compare)
module decimal_tape_min_prefix_sum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_final_balance,
   output logic [63:0] rsp_lowest_balance,
   output logic        rsp_overflow
);
   import dtmps_pkg::*;

   // input register
   logic              in_valid_ff;
   logic [7:0]        char_ff;
   logic              end_ff;

   // result register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] final_ff;
   logic [WORD_W-1:0] lowest_ff;
   logic              ovf_ff;

   logic              out_free;
   logic              step;
   token_type         tok;
   tally_type         res;

   // the held byte advances whenever the result slot can take a result
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;

   dtmps_token u_token (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .char_byte  (char_ff),
      .stream_end (end_ff),
      .tok        (tok)
   );

   dtmps_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .stream_end (end_ff),
      .tok        (tok),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_byte;
         end_ff  <= req_stream_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && res.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload of the result register
   always_ff @(posedge clock) begin
      if (step && res.emit) begin
         final_ff  <= res.final_balance;
         lowest_ff <= res.lowest_balance;
         ovf_ff    <= res.overflow;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_final_balance  = final_ff;
   assign rsp_lowest_balance = lowest_ff;
   assign rsp_overflow       = ovf_ff;

endmodule

// ===== rtl/dtmps_token.sv =====
// token parser: sign, magnitude and signed value of the pending decimal token
module dtmps_token (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            char_byte,
   input  logic                  stream_end,
   output dtmps_pkg::token_type  tok
);
   import dtmps_pkg::*;

   phase_type         phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic [WORD_W-1:0] mag_ff, mag_in;
   logic [WORD_W-1:0] sval_ff, sval_in;

   logic              is_digit;
   logic              is_minus;
   logic [3:0]        dval;
   logic [WORD_W+3:0] mag10;
   logic [WORD_W-1:0] sval10;
   logic [WORD_W-1:0] dext;

   always_comb begin
      is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
      is_minus = (char_byte == CHAR_MINUS);
      dval     = 4'(char_byte - CHAR_ZERO);
      dext     = {{(WORD_W-4){1'b0}}, dval};
      // exact magnitude times ten plus digit, wide enough to see overflow
      mag10    = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + {{WORD_W{1'b0}}, dval};
      // two's complement value follows the magnitude, negated when signed
      sval10   = neg_ff ? ((sval_ff << 3) + (sval_ff << 1) - dext)
                        : ((sval_ff << 3) + (sval_ff << 1) + dext);
   end

   always_comb begin
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      sval_in       = sval_ff;
      tok.close     = 1'b0;
      tok.value     = sval_ff;
      tok.neg_ovf   = neg_ff && (mag_ff == {1'b1, {(WORD_W-1){1'b0}}});
      tok.digit_ovf = 1'b0;

      if (phase_ff == PH_SIGN || phase_ff == PH_DIGITS) begin
         if (is_digit) begin
            phase_in      = PH_DIGITS;
            mag_in        = mag10[WORD_W-1:0];
            sval_in       = sval10;
            tok.digit_ovf = |mag10[WORD_W+3:WORD_W-1];
         end else begin
            // terminating byte is consumed with the token
            tok.close = 1'b1;
            phase_in  = PH_SKIP;
            neg_in    = 1'b0;
            mag_in    = '0;
            sval_in   = '0;
         end
      end else begin
         if (is_minus) begin
            phase_in = PH_SIGN;
            neg_in   = 1'b1;
            mag_in   = '0;
            sval_in  = '0;
         end else if (is_digit) begin
            phase_in = PH_DIGITS;
            neg_in   = 1'b0;
            mag_in   = dext;
            sval_in  = dext;
         end else begin
            phase_in = PH_SKIP;
         end
      end

      if (stream_end) begin
         // end of stream closes a token still open after this byte
         if (!tok.close && (phase_in == PH_SIGN || phase_in == PH_DIGITS)) begin
            tok.close   = 1'b1;
            tok.value   = sval_in;
            tok.neg_ovf = neg_in && (mag_in == {1'b1, {(WORD_W-1){1'b0}}});
         end
         phase_in = PH_SKIP;
         neg_in   = 1'b0;
         mag_in   = '0;
         sval_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         sval_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
         sval_ff  <= sval_in;
      end
   end

endmodule

// ===== rtl/dtmps_tally.sv =====
// tape tally: header count, running balance, lowest balance, sticky overflow
module dtmps_tally (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  stream_end,
   input  dtmps_pkg::token_type  tok,
   output dtmps_pkg::tally_type  res
);
   import dtmps_pkg::*;

   logic              hdr_ff, hdr_in;
   logic [WORD_W-1:0] left_ff, left_in;
   logic [WORD_W-1:0] bal_ff, bal_in;
   logic [WORD_W-1:0] low_ff, low_in;
   logic              ovf_ff, ovf_in;

   logic [WORD_W-1:0] sum;

   assign sum = bal_ff + tok.value;

   always_comb begin
      hdr_in  = hdr_ff;
      left_in = left_ff;
      bal_in  = bal_ff;
      low_in  = low_ff;
      ovf_in  = ovf_ff | tok.digit_ovf;
      res.emit           = 1'b0;
      res.final_balance  = bal_ff;
      res.lowest_balance = low_ff;
      res.overflow       = 1'b0;

      if (tok.close) begin
         ovf_in = ovf_in | tok.neg_ovf;
         if (!hdr_ff) begin
            if (tok.value == '0 || tok.value[WORD_W-1]) begin
               res.emit = 1'b1;
            end else begin
               hdr_in  = 1'b1;
               left_in = tok.value;
               bal_in  = '0;
               low_in  = '0;
            end
         end else begin
            if ((bal_ff[WORD_W-1] == tok.value[WORD_W-1]) &&
                (sum[WORD_W-1] != bal_ff[WORD_W-1])) begin
               ovf_in = 1'b1;
            end
            bal_in = sum;
            if ($signed(sum) < $signed(low_ff)) begin
               low_in = sum;
            end
            left_in = left_ff - 1'b1;
            if (left_ff == {{(WORD_W-1){1'b0}}, 1'b1}) begin
               res.emit = 1'b1;
            end
         end
      end

      // truncated tape still reports what it reached
      if (stream_end && !res.emit && hdr_in) begin
         res.emit = 1'b1;
      end

      res.final_balance  = bal_in;
      res.lowest_balance = low_in;
      res.overflow       = ovf_in;

      if (res.emit || stream_end) begin
         hdr_in  = 1'b0;
         left_in = '0;
         bal_in  = '0;
         low_in  = '0;
         ovf_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= 1'b0;
         left_ff <= '0;
         bal_ff  <= '0;
         low_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (step) begin
         hdr_ff  <= hdr_in;
         left_ff <= left_in;
         bal_ff  <= bal_in;
         low_ff  <= low_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule
